FILE: rtl/rgbb_pkg.sv
// Package for the RGB breathing pattern generator: beat types, codes and helpers.
package rgbb_pkg;

    typedef enum logic [1:0] {
        CMD_TICK     = 2'd0,
        CMD_SET_MODE = 2'd1,
        CMD_FADE_ON  = 2'd2,
        CMD_FADE_OFF = 2'd3
    } cmd_t;

    localparam logic [3:0] MODE_IDLE       = 4'd0;
    localparam logic [3:0] MODE_BLUE       = 4'd1;
    localparam logic [3:0] MODE_RED        = 4'd2;
    localparam logic [3:0] MODE_GREEN      = 4'd3;
    localparam logic [3:0] MODE_YELLOW     = 4'd4;
    localparam logic [3:0] MODE_WHITE      = 4'd5;
    localparam logic [3:0] MODE_FADE_ON    = 4'd6;
    localparam logic [3:0] MODE_FADE_OFF   = 4'd7;
    localparam logic [3:0] MODE_HALF_WHITE = 4'd8;

    localparam logic [1:0] FADE_NONE = 2'd0;
    localparam logic [1:0] FADE_ON   = 2'd1;
    localparam logic [1:0] FADE_OFF  = 2'd2;

    localparam logic [6:0] PHASE_PEAK       = 7'd20;
    localparam logic [6:0] PHASE_TRI_END    = 7'd39;
    localparam logic [6:0] PHASE_TRI_BASE   = 7'd40;
    localparam logic [6:0] PHASE_PLATEAU    = 7'd46;
    localparam logic [6:0] PHASE_WHITE_END  = 7'd65;
    localparam logic [6:0] PHASE_WHITE_BASE = 7'd66;
    localparam logic [6:0] PHASE_HALF_PEAK  = 7'd15;
    localparam logic [6:0] PHASE_HALF_END   = 7'd60;
    localparam logic [6:0] PHASE_HALF_BASE  = 7'd61;

    typedef struct packed {
        cmd_t       cmd;
        logic [3:0] pattern_code;
    } in_beat_t;

    typedef struct packed {
        logic [4:0] red_level;
        logic [4:0] green_level;
        logic [4:0] blue_level;
        logic       white_seen;
        logic       pattern_running;
        logic       fade_busy;
        logic [1:0] last_fade_done;
    } out_beat_t;

    function automatic logic colour_valid(input logic [3:0] code);
        logic ok;
        begin
            ok = (code inside {[MODE_BLUE:MODE_WHITE], MODE_HALF_WHITE});
            return ok;
        end
    endfunction

endpackage

FILE: rtl/rgb_breathing_pattern.sv
// Top level of the RGB breathing pattern generator: command decode, pattern state, result beat.
//
// One input beat is taken every clock cycle while the input side is not stalled. Its result beat
// is valid in the cycle after it is accepted and comes straight from the pattern state registers,
// which are the result register. The input side stalls only while a result beat is held and the
// output side stalls, so throughput is one beat per cycle while the output does not stall. Every
// other tick advances a running pattern's phase counter; the levels are held between advances.
module rgb_breathing_pattern
    import rgbb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_beat_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_beat_t out_data
);

    logic       parity_reg, parity_next;
    logic [6:0] phase_reg, phase_next;
    logic [3:0] mode_reg, mode_next;
    logic [1:0] fade_kind_reg, fade_kind_next;
    logic [3:0] fade_pat_reg, fade_pat_next;
    logic [1:0] last_fade_reg, last_fade_next;
    logic [4:0] red_reg, red_next;
    logic [4:0] green_reg, green_next;
    logic [4:0] blue_reg, blue_next;
    logic       white_reg, white_next;
    logic       out_valid_reg, out_valid_next;

    logic       accept;
    logic       do_advance;
    logic       is_fade;
    logic       fade_end;
    logic [3:0] colour;
    logic [6:0] phase_inc;
    logic [6:0] tri_lvl;

    assign in_stall = out_valid_reg & out_stall;
    assign accept   = in_valid & ~in_stall;

    // next state
    always_comb
    begin
        parity_next    = parity_reg;
        phase_next     = phase_reg;
        mode_next      = mode_reg;
        fade_kind_next = fade_kind_reg;
        fade_pat_next  = fade_pat_reg;
        last_fade_next = last_fade_reg;
        red_next       = red_reg;
        green_next     = green_reg;
        blue_next      = blue_reg;
        white_next     = white_reg;
        do_advance     = 1'b0;
        is_fade        = (mode_reg == MODE_FADE_ON) || (mode_reg == MODE_FADE_OFF);
        fade_end       = 1'b0;
        colour         = MODE_IDLE;
        phase_inc      = phase_reg + 7'd1;
        tri_lvl        = (phase_inc > PHASE_PEAK) ? (PHASE_TRI_BASE - phase_inc) : phase_inc;

        if (accept)
        begin
            case (in_data.cmd)
                CMD_TICK:
                begin
                    parity_next = ~parity_reg;
                    do_advance  = ~parity_reg;
                end
                CMD_SET_MODE:
                begin
                    mode_next      = colour_valid(in_data.pattern_code) ?
                                     in_data.pattern_code : MODE_IDLE;
                    fade_kind_next = FADE_NONE;
                end
                CMD_FADE_ON:
                begin
                    phase_next     = 7'd0;
                    fade_pat_next  = in_data.pattern_code;
                    mode_next      = MODE_FADE_ON;
                    fade_kind_next = FADE_ON;
                end
                default:
                begin
                    phase_next     = PHASE_PEAK;
                    fade_pat_next  = in_data.pattern_code;
                    mode_next      = MODE_FADE_OFF;
                    fade_kind_next = FADE_OFF;
                end
            endcase
        end

        if (do_advance)
        begin
            if (is_fade)
            begin
                fade_end = !colour_valid(fade_pat_reg) ||
                           (phase_reg == ((mode_reg == MODE_FADE_ON) ? PHASE_PEAK : 7'd1));
                colour   = fade_end ? MODE_IDLE : fade_pat_reg;
            end
            else
            begin
                colour = mode_reg;
            end

            if (fade_end)
            begin
                mode_next      = MODE_IDLE;
                fade_kind_next = FADE_NONE;
                last_fade_next = (mode_reg == MODE_FADE_ON) ? FADE_ON : FADE_OFF;
            end

            case (colour)
                MODE_BLUE, MODE_RED, MODE_YELLOW:
                begin
                    phase_next = (phase_inc > PHASE_TRI_END) ? 7'd1 : phase_inc;
                    if (colour == MODE_BLUE)
                    begin
                        red_next   = 5'd0;
                        green_next = 5'd0;
                        if (phase_inc <= PHASE_TRI_END)
                            blue_next = tri_lvl[4:0];
                    end
                    else if (colour == MODE_RED)
                    begin
                        blue_next  = 5'd0;
                        green_next = 5'd0;
                        if (phase_inc <= PHASE_TRI_END)
                            red_next = tri_lvl[4:0];
                    end
                    else
                    begin
                        blue_next = 5'd0;
                        if (phase_inc <= PHASE_TRI_END)
                            green_next = tri_lvl[4:0];
                        red_next = (phase_inc <= PHASE_TRI_END) ? tri_lvl[4:0] : green_reg;
                    end
                end
                MODE_GREEN:
                begin
                    blue_next  = 5'd0;
                    red_next   = 5'd0;
                    green_next = (phase_inc >= PHASE_TRI_BASE) ? 5'd0 : tri_lvl[4:0];
                    phase_next = (phase_inc > PHASE_TRI_END) ? 7'd1 : phase_inc;
                end
                MODE_WHITE:
                begin
                    phase_next = phase_inc;
                    if (phase_inc > PHASE_WHITE_END)
                        phase_next = 7'd1;
                    else if (phase_inc > PHASE_PLATEAU)
                        green_next = 5'(PHASE_WHITE_BASE - phase_inc);
                    else if (phase_inc > PHASE_PEAK)
                        green_next = PHASE_PEAK[4:0];
                    else
                        green_next = phase_inc[4:0];
                    red_next   = green_next;
                    blue_next  = green_next;
                    white_next = 1'b1;
                end
                MODE_HALF_WHITE:
                begin
                    phase_next = phase_inc;
                    if (phase_inc > PHASE_HALF_END)
                        phase_next = 7'd1;
                    else if (phase_inc > PHASE_PLATEAU)
                        green_next = 5'(PHASE_HALF_BASE - phase_inc);
                    else if (phase_inc > PHASE_HALF_PEAK)
                        green_next = PHASE_HALF_PEAK[4:0];
                    else
                        green_next = phase_inc[4:0];
                    red_next   = green_next;
                    blue_next  = green_next;
                    white_next = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // output handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parity_reg    <= 1'b0;
            phase_reg     <= 7'd0;
            mode_reg      <= MODE_IDLE;
            fade_kind_reg <= FADE_NONE;
            fade_pat_reg  <= 4'd0;
            last_fade_reg <= FADE_NONE;
            red_reg       <= 5'd0;
            green_reg     <= 5'd0;
            blue_reg      <= 5'd0;
            white_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            parity_reg    <= parity_next;
            phase_reg     <= phase_next;
            mode_reg      <= mode_next;
            fade_kind_reg <= fade_kind_next;
            fade_pat_reg  <= fade_pat_next;
            last_fade_reg <= last_fade_next;
            red_reg       <= red_next;
            green_reg     <= green_next;
            blue_reg      <= blue_next;
            white_reg     <= white_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid                = out_valid_reg;
    assign out_data.red_level       = red_reg;
    assign out_data.green_level     = green_reg;
    assign out_data.blue_level      = blue_reg;
    assign out_data.white_seen      = white_reg;
    assign out_data.pattern_running = (mode_reg != MODE_IDLE);
    assign out_data.fade_busy       = (fade_kind_reg != FADE_NONE);
    assign out_data.last_fade_done  = last_fade_reg;

    a_fade_implies_running: assert property (@(posedge clk) disable iff (!rst_n)
        (fade_kind_reg != FADE_NONE) |-> (mode_reg == MODE_FADE_ON || mode_reg == MODE_FADE_OFF))
        else $error("fade in progress without a fade mode");

    a_levels_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (red_reg <= 5'd20) && (green_reg <= 5'd20) && (blue_reg <= 5'd20))
        else $error("level above peak");

    a_phase_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= PHASE_WHITE_END)
        else $error("phase out of range");

    a_accept_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid)
        else $error("accepted beat without a result beat");

    a_state_held_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> $stable(out_data))
        else $error("result changed while output stalled");

endmodule

FILE: test/rgb_breathing_pattern_tb.sv
// Testbench for rgb_breathing_pattern: scoreboard with level predictor, beat driver and checks.
import rgbb_pkg::*;

class breath_scoreboard;
    bit          parity;
    logic [6:0]  phase;
    logic [3:0]  mode;
    logic [3:0]  fade_colour;
    logic [1:0]  fade_dir;
    logic [1:0]  last_done;
    logic [4:0]  red;
    logic [4:0]  green;
    logic [4:0]  blue;
    bit          white_hit;
    out_beat_t   due_levels[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned advances;
    int unsigned fades_done;

    function new();
        parity      = 1'b0;
        phase       = '0;
        mode        = MODE_IDLE;
        fade_colour = '0;
        fade_dir    = FADE_NONE;
        last_done   = FADE_NONE;
        red         = '0;
        green       = '0;
        blue        = '0;
        white_hit   = 1'b0;
        mismatches  = 0;
        checked     = 0;
        advances    = 0;
        fades_done  = 0;
    endfunction

    function bit is_colour(logic [3:0] c);
        return (c >= MODE_BLUE && c <= MODE_WHITE) || c == MODE_HALF_WHITE;
    endfunction

    // Triangle 1..20..1; past the end the phase wraps and the level is held.
    function bit tri_step(output logic [4:0] lvl);
        lvl = '0;
        if (phase > PHASE_TRI_END)
        begin
            phase = 7'd1;
            return 1'b0;
        end
        lvl = (phase > PHASE_PEAK) ? 5'(PHASE_TRI_BASE - phase) : 5'(phase);
        return 1'b1;
    endfunction

    function void step_colour(logic [3:0] c);
        logic [4:0] lvl;
        case (c)
            MODE_BLUE:
            begin
                red   = '0;
                green = '0;
                phase = phase + 7'd1;
                if (tri_step(lvl))
                    blue = lvl;
            end
            MODE_RED:
            begin
                blue  = '0;
                green = '0;
                phase = phase + 7'd1;
                if (tri_step(lvl))
                    red = lvl;
            end
            MODE_GREEN:
            begin
                blue  = '0;
                red   = '0;
                phase = phase + 7'd1;
                // green emits 0 at phase 40 before wrapping
                if (phase >= PHASE_TRI_BASE)
                    green = '0;
                else if (phase > PHASE_PEAK)
                    green = 5'(PHASE_TRI_BASE - phase);
                else
                    green = 5'(phase);
                if (phase > PHASE_TRI_END)
                    phase = 7'd1;
            end
            MODE_YELLOW:
            begin
                blue  = '0;
                phase = phase + 7'd1;
                if (tri_step(lvl))
                    green = lvl;
                red = green;
            end
            MODE_WHITE:
            begin
                phase = phase + 7'd1;
                if (phase > PHASE_WHITE_END)
                    phase = 7'd1;
                else if (phase > PHASE_PLATEAU)
                    green = 5'(PHASE_WHITE_BASE - phase);
                else if (phase > PHASE_PEAK)
                    green = 5'(PHASE_PEAK);
                else
                    green = 5'(phase);
                red       = green;
                blue      = green;
                white_hit = 1'b1;
            end
            MODE_HALF_WHITE:
            begin
                phase = phase + 7'd1;
                if (phase > PHASE_HALF_END)
                    phase = 7'd1;
                else if (phase > PHASE_PLATEAU)
                    green = 5'(PHASE_HALF_BASE - phase);
                else if (phase > PHASE_HALF_PEAK)
                    green = 5'(PHASE_HALF_PEAK);
                else
                    green = 5'(phase);
                red       = green;
                blue      = green;
                white_hit = 1'b1;
            end
            default:
            begin
            end
        endcase
    endfunction

    function void advance();
        bit         rising;
        logic [6:0] target;
        advances++;
        if (mode == MODE_FADE_ON || mode == MODE_FADE_OFF)
        begin
            rising = (mode == MODE_FADE_ON);
            target = rising ? PHASE_PEAK : 7'd1;
            if (!is_colour(fade_colour) || phase == target)
            begin
                mode      = MODE_IDLE;
                fade_dir  = FADE_NONE;
                last_done = rising ? FADE_ON : FADE_OFF;
                fades_done++;
            end
            else
                step_colour(fade_colour);
        end
        else if (is_colour(mode))
            step_colour(mode);
    endfunction

    function void note_beat(in_beat_t b);
        out_beat_t o;
        case (b.cmd)
            CMD_TICK:
            begin
                parity = ~parity;
                if (parity)
                    advance();
            end
            CMD_SET_MODE:
            begin
                mode     = is_colour(b.pattern_code) ? b.pattern_code : MODE_IDLE;
                fade_dir = FADE_NONE;
            end
            CMD_FADE_ON:
            begin
                phase       = '0;
                fade_colour = b.pattern_code;
                mode        = MODE_FADE_ON;
                fade_dir    = FADE_ON;
            end
            default:
            begin
                phase       = PHASE_PEAK;
                fade_colour = b.pattern_code;
                mode        = MODE_FADE_OFF;
                fade_dir    = FADE_OFF;
            end
        endcase
        o.red_level       = red;
        o.green_level     = green;
        o.blue_level      = blue;
        o.white_seen      = white_hit;
        o.pattern_running = (mode != MODE_IDLE);
        o.fade_busy       = (fade_dir != FADE_NONE);
        o.last_fade_done  = last_done;
        due_levels.push_back(o);
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch in %s, result %0d: expected %0d, got %0d",
                         name, checked, want, got);
        end
    endfunction

    function void check_beat(out_beat_t got);
        out_beat_t want;
        if (due_levels.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result beat %0h with nothing outstanding", got);
            return;
        end
        want = due_levels.pop_front();
        check_field("red_level", want.red_level, got.red_level);
        check_field("green_level", want.green_level, got.green_level);
        check_field("blue_level", want.blue_level, got.blue_level);
        check_field("white_seen", want.white_seen, got.white_seen);
        check_field("pattern_running", want.pattern_running, got.pattern_running);
        check_field("fade_busy", want.fade_busy, got.fade_busy);
        check_field("last_fade_done", want.last_fade_done, got.last_fade_done);
        checked++;
    endfunction

    function int pending();
        return due_levels.size();
    endfunction
endclass

module rgb_breathing_pattern_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT  = 1000;
    localparam int RANDOM_BEATS = 1800;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    in_beat_t  in_data   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_beat_t out_data;

    breath_scoreboard sb = new();
    int unsigned      quiet_cycles = 0;
    int unsigned      burst_left   = 0;
    int unsigned      sent         = 0;

    rgb_breathing_pattern dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_beat(out_data);
            if (in_valid && !in_stall)
                sb.note_beat(in_data);
            if ((out_valid && !out_stall) || (in_valid && !in_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // receiver: stretches of no stall, light stall, heavy stall and toggling
    initial
    begin
        int style;
        int span;
        forever
        begin
            style = $urandom_range(0, 3);
            span  = $urandom_range(8, 64);
            repeat (span)
            begin
                @(posedge clk);
                case (style)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= ~out_stall;
                endcase
            end
        end
    end

    task automatic send_beat(input cmd_t c, input logic [3:0] code);
        in_beat_t b;
        b.cmd          = c;
        b.pattern_code = code;
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 40);
        end
        in_data  <= b;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        burst_left--;
        sent++;
    endtask

    task automatic send_ticks(input int n);
        repeat (n)
            send_beat(CMD_TICK, 4'($urandom_range(0, 15)));
    endtask

    function automatic logic [3:0] pick_colour();
        logic [3:0] colours[6];
        colours = '{MODE_BLUE, MODE_RED, MODE_GREEN, MODE_YELLOW, MODE_WHITE, MODE_HALF_WHITE};
        if ($urandom_range(0, 7) == 0)
            return 4'($urandom_range(0, 15));
        return colours[$urandom_range(0, 5)];
    endfunction

    function automatic cmd_t pick_fade();
        return ($urandom_range(0, 1) == 0) ? CMD_FADE_ON : CMD_FADE_OFF;
    endfunction

    initial
    begin
        int pick;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // idle ticks, bad mode, bad fade colours, restart and abandon of fades
        send_beat(CMD_TICK, 4'd15);
        send_beat(CMD_TICK, 4'd0);
        send_beat(CMD_SET_MODE, 4'd15);
        send_beat(CMD_TICK, 4'd9);
        send_beat(CMD_FADE_ON, MODE_IDLE);
        send_ticks(2);
        send_beat(CMD_FADE_OFF, MODE_FADE_OFF);
        send_ticks(2);
        send_beat(CMD_SET_MODE, MODE_WHITE);
        send_ticks(2);
        send_beat(CMD_FADE_ON, MODE_BLUE);
        send_ticks(2);
        send_beat(CMD_FADE_OFF, MODE_RED);
        send_ticks(2);
        send_beat(CMD_SET_MODE, MODE_GREEN);
        send_ticks(2);
        send_beat(CMD_SET_MODE, MODE_FADE_ON);
        send_beat(CMD_SET_MODE, MODE_HALF_WHITE);
        send_ticks(1);

        pick = 0;
        while (sent < 25 + RANDOM_BEATS)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 4)
            begin
                send_beat(CMD_SET_MODE, pick_colour());
                send_ticks($urandom_range(10, 150));
            end
            else if (pick < 7)
            begin
                send_beat(pick_fade(), pick_colour());
                send_ticks($urandom_range(30, 110));
            end
            else if (pick == 7)
            begin
                send_beat(pick_fade(), pick_colour());
                send_ticks($urandom_range(4, 30));
                send_beat(pick_fade(), pick_colour());
                send_ticks($urandom_range(40, 100));
            end
            else
            begin
                repeat ($urandom_range(1, 8))
                    send_beat(cmd_t'($urandom_range(0, 3)), 4'($urandom_range(0, 15)));
            end
        end
        in_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Drove %0d command beats: %0d pattern advances, %0d fades run to their end.",
                 sent, sb.advances, sb.fades_done);
        $display("Compared %0d result beats field by field, %0d mismatches.",
                 sb.checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("** rgb_breathing_pattern: PASSED **");
        else
            $display("** rgb_breathing_pattern: FAILED **");
        $finish;
    end

    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("watchdog: no beat moved for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, sb.pending());
        $display("** rgb_breathing_pattern: FAILED **");
        $finish;
    end
endmodule
